[src/mlfq_pkg.sv]
// shared types and constants of the multilevel feedback queue scheduler
package mlfq_pkg;
  localparam int unsigned MaxProcs  = 64;
  localparam int unsigned MaxLevels = 8;

  localparam logic [1:0] KindArrive   = 2'd0;
  localparam logic [1:0] KindTick     = 2'd1;
  localparam logic [1:0] KindDispatch = 2'd2;

  localparam logic [1:0] CfgNumLevels  = 2'd0;
  localparam logic [1:0] CfgBoostPer   = 2'd1;
  localparam logic [1:0] CfgQuantums   = 2'd2;
  localparam logic [1:0] CfgAllotments = 2'd3;

  typedef struct packed {
    logic [1:0] kind;
    logic [5:0] process_id;
    logic       running_valid;
    logic [5:0] running_id;
    logic       preempt_pending;
  } in_item_t;

  typedef struct packed {
    logic       preempt_request;
    logic       dispatch_valid;
    logic [5:0] dispatch_id;
    logic       running_requeued;
  } out_item_t;
endpackage

[src/mlfq_in_if.sv]
// input event channel
interface mlfq_in_if;
  logic                valid;
  logic                ready;
  mlfq_pkg::in_item_t  data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/mlfq_out_if.sv]
// result channel
interface mlfq_out_if;
  logic                valid;
  logic                ready;
  mlfq_pkg::out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/mlfq_proc_mem.sv]
// per-process memory with one write port and one registered read port
module mlfq_proc_mem #(
  parameter int unsigned MAX_PROCS = mlfq_pkg::MaxProcs,
  parameter int unsigned WIDTH     = $clog2(mlfq_pkg::MaxProcs)
) (
  input  logic                         clk_i,
  input  logic                         we_i,
  input  logic [$clog2(MAX_PROCS)-1:0] waddr_i,
  input  logic [WIDTH-1:0]             wdata_i,
  input  logic [$clog2(MAX_PROCS)-1:0] raddr_i,
  output logic [WIDTH-1:0]             rdata_o
);
  logic [WIDTH-1:0] mem_q [MAX_PROCS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule

[src/mlfq_scheduler.sv]
// multilevel feedback queue scheduler top level
//
// events (arrival, tick, dispatch request) come in on in_if, one transfer per
// event, and every accepted event gives exactly one result transfer on out_if.
// configuration is written through cfg_we_i / cfg_idx_i / cfg_data_i by the
// user only while no event is in work; the block does not enforce this. the
// per-process links and level/allotment words sit in two memories with a
// registered read; queue heads and tails are per-level flops. arrival,
// dispatch and normal ticks pass through the read, execute and done states,
// and the input is ready again once the result is registered, so events do
// not overlap. a boost tick splices one level list per cycle onto level 0. a
// boost clears every level and allotment at once through one fresh bit per
// process, so memory contents never need clearing. reset empties all queues
// and clears the boost and quantum counters. the result waits in an output
// register; when the receiver stalls, one more event is taken and held
// finished until that register frees, and the input stops meanwhile.
module mlfq_scheduler #(
  parameter int unsigned MAX_PROCS  = mlfq_pkg::MaxProcs,
  parameter int unsigned MAX_LEVELS = mlfq_pkg::MaxLevels
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [63:0] cfg_data_i,
  mlfq_in_if.sink     in_if,
  mlfq_out_if.source  out_if
);
  import mlfq_pkg::*;

  localparam int unsigned PW = $clog2(MAX_PROCS);
  localparam int unsigned LW = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int unsigned IW = 11;
  localparam logic [LW-1:0] LastLvl = LW'(MAX_LEVELS - 1);

  localparam logic [2:0] StIdle  = 3'd0;
  localparam logic [2:0] StRead  = 3'd1;
  localparam logic [2:0] StExec  = 3'd2;
  localparam logic [2:0] StBoost = 3'd3;
  localparam logic [2:0] StPush  = 3'd4;
  localparam logic [2:0] StDone  = 3'd5;

  // configuration
  logic [3:0]  nlev_q;
  logic [15:0] bper_q;
  logic [63:0] quant_q, allot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nlev_q  <= 4'd3;
      bper_q  <= 16'd100;
      quant_q <= 64'd578721382704613384;
      allot_q <= 64'd1157442765409226768;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgNumLevels:  nlev_q  <= cfg_data_i[3:0];
        CfgBoostPer:   bper_q  <= cfg_data_i[15:0];
        CfgQuantums:   quant_q <= cfg_data_i;
        CfgAllotments: allot_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  logic [3:0] nuse;
  always_comb begin
    nuse = nlev_q;
    if (nuse == 4'd0) nuse = 4'd1;
    if (nuse > 4'(MAX_LEVELS)) nuse = 4'(MAX_LEVELS);
  end
  logic [2:0] last_lvl;
  assign last_lvl = 3'(nuse - 4'd1);

  // state
  logic [2:0]            st_q, st_d;
  in_item_t              it_q;
  logic [PW-1:0]         head_q [MAX_LEVELS];
  logic [PW-1:0]         head_d [MAX_LEVELS];
  logic [PW-1:0]         tail_q [MAX_LEVELS];
  logic [PW-1:0]         tail_d [MAX_LEVELS];
  logic [MAX_LEVELS-1:0] ne_q, ne_d;
  logic [16:0]           bcnt_q, bcnt_d;
  logic [8:0]            qleft_q, qleft_d;
  logic [MAX_PROCS-1:0]  fresh_q, fresh_d;
  logic [LW-1:0]         bl_q, bl_d;
  out_item_t             res_q, res_d, ov_q, ov_d;
  logic                  ovalid_q, ovalid_d;

  // memories: next link, and {level, allotment used}
  logic          link_we, info_we;
  logic [PW-1:0] link_waddr, link_raddr, info_waddr;
  logic [PW-1:0] link_wdata, link_rdata;
  logic [IW-1:0] info_wdata, info_rdata;

  logic [PW-1:0] pid_in, rid_in;
  assign pid_in = PW'(it_q.process_id);
  assign rid_in = PW'(it_q.running_id);

  mlfq_proc_mem #(.MAX_PROCS(MAX_PROCS), .WIDTH(PW)) u_link_mem (
    .clk_i   (clk_i),
    .we_i    (link_we),
    .waddr_i (link_waddr),
    .wdata_i (link_wdata),
    .raddr_i (link_raddr),
    .rdata_o (link_rdata)
  );

  mlfq_proc_mem #(.MAX_PROCS(MAX_PROCS), .WIDTH(IW)) u_info_mem (
    .clk_i   (clk_i),
    .we_i    (info_we),
    .waddr_i (info_waddr),
    .wdata_i (info_wdata),
    .raddr_i (rid_in),
    .rdata_o (info_rdata)
  );

  logic       r_fresh;
  logic [2:0] r_lvl;
  logic [7:0] r_used;
  assign r_fresh = fresh_q[rid_in];
  assign r_lvl   = r_fresh ? info_rdata[10:8] : 3'd0;
  assign r_used  = r_fresh ? info_rdata[7:0] : 8'd0;

  // dispatch search
  logic          d_found;
  logic [LW-1:0] d_lvl;
  always_comb begin
    d_found = 1'b0;
    d_lvl   = '0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (ne_q[i] && (4'(i) < nuse)) begin
        d_found = 1'b1;
        d_lvl   = LW'(i);
      end
    end
  end

  // tick evaluation
  logic [16:0] bcnt_n;
  logic        boost;
  logic [7:0]  used_n;
  logic [8:0]  q_n;
  logic [2:0]  lcap, ldem;
  logic [7:0]  alim;
  logic        demote;
  assign bcnt_n = bcnt_q + 17'd1;
  assign boost  = bcnt_n >= {1'b0, bper_q};
  always_comb begin
    used_n = (r_used != 8'hFF) ? r_used + 8'd1 : r_used;
    q_n    = (qleft_q != 9'd0) ? qleft_q - 9'd1 : 9'd0;
    lcap   = (r_lvl > last_lvl) ? last_lvl : r_lvl;
    ldem   = (lcap < last_lvl) ? lcap + 3'd1 : lcap;
    alim   = allot_q[{r_lvl, 3'b000} +: 8];
    demote = used_n >= alim;
  end

  assign in_if.ready  = st_q == StIdle;
  assign out_if.valid = ovalid_q;
  assign out_if.data  = ov_q;

  logic          push_en;
  logic [LW-1:0] push_lvl;
  logic [PW-1:0] push_id;

  always_comb begin
    st_d       = st_q;
    head_d     = head_q;
    tail_d     = tail_q;
    ne_d       = ne_q;
    bcnt_d     = bcnt_q;
    qleft_d    = qleft_q;
    fresh_d    = fresh_q;
    bl_d       = bl_q;
    res_d      = res_q;
    ov_d       = ov_q;
    ovalid_d   = ovalid_q;
    push_en    = 1'b0;
    push_lvl   = '0;
    push_id    = rid_in;
    link_we    = 1'b0;
    link_waddr = tail_q[0];
    link_wdata = rid_in;
    link_raddr = head_q[d_lvl];
    info_we    = 1'b0;
    info_waddr = rid_in;
    info_wdata = {lcap, used_n};
    if (ovalid_q && out_if.ready) ovalid_d = 1'b0;
    unique case (st_q)
      StIdle: begin
        if (in_if.valid) st_d = StRead;
      end
      StRead: begin
        res_d = '0;
        st_d  = StExec;
        case (it_q.kind)
          KindTick: begin
            if (boost) begin
              bcnt_d  = '0;
              fresh_d = '0;
              bl_d    = LW'(1);
              st_d    = (MAX_LEVELS > 1) ? StBoost : StPush;
            end else begin
              bcnt_d = bcnt_n;
            end
          end
          KindArrive: ;
          KindDispatch: ;
          default: st_d = StDone;
        endcase
      end
      StExec: begin
        st_d = StDone;
        case (it_q.kind)
          KindArrive: begin
            info_we         = 1'b1;
            info_waddr      = pid_in;
            info_wdata      = '0;
            fresh_d[pid_in] = 1'b1;
            push_en         = 1'b1;
            push_id         = pid_in;
            res_d.preempt_request = it_q.running_valid && (rid_in != pid_in)
                                    && (r_lvl != 3'd0);
          end
          KindDispatch: begin
            if (d_found) begin
              res_d.dispatch_valid = 1'b1;
              res_d.dispatch_id    = 6'(head_q[d_lvl]);
              qleft_d = {1'b0, quant_q[8*d_lvl +: 8]};
              if (head_q[d_lvl] == tail_q[d_lvl]) ne_d[d_lvl] = 1'b0;
              else head_d[d_lvl] = link_rdata;
            end
          end
          KindTick: begin
            if (it_q.running_valid) begin
              qleft_d         = q_n;
              info_we         = 1'b1;
              fresh_d[rid_in] = 1'b1;
              push_lvl        = LW'(lcap);
              if (demote) begin
                info_wdata               = {ldem, 8'd0};
                push_lvl                 = LW'(ldem);
                push_en                  = 1'b1;
                res_d.preempt_request    = 1'b1;
                res_d.running_requeued   = 1'b1;
              end else if (q_n == 9'd0) begin
                push_en                  = 1'b1;
                res_d.preempt_request    = 1'b1;
                res_d.running_requeued   = 1'b1;
              end else if (it_q.preempt_pending) begin
                push_en                  = 1'b1;
                res_d.running_requeued   = 1'b1;
              end else begin
                info_wdata = {r_lvl, used_n};
              end
            end
          end
          default: ;
        endcase
      end
      StBoost: begin
        // splice one level list onto level 0
        if (ne_q[bl_q] && (4'(bl_q) < nuse)) begin
          if (ne_q[0]) begin
            link_we    = 1'b1;
            link_waddr = tail_q[0];
            link_wdata = head_q[bl_q];
          end else begin
            head_d[0] = head_q[bl_q];
            ne_d[0]   = 1'b1;
          end
          tail_d[0]  = tail_q[bl_q];
          ne_d[bl_q] = 1'b0;
        end
        bl_d = bl_q + LW'(1);
        if (bl_q == LastLvl) st_d = StPush;
      end
      StPush: begin
        st_d = StDone;
        if (it_q.running_valid) begin
          push_en                = 1'b1;
          res_d.preempt_request  = 1'b1;
          res_d.running_requeued = 1'b1;
        end
      end
      StDone: begin
        if (!ovalid_q || out_if.ready) begin
          ov_d     = res_q;
          ovalid_d = 1'b1;
          st_d     = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
    // append to the tail of a level
    if (push_en) begin
      if (ne_q[push_lvl]) begin
        link_we    = 1'b1;
        link_waddr = tail_q[push_lvl];
        link_wdata = push_id;
      end else begin
        head_d[push_lvl] = push_id;
        ne_d[push_lvl]   = 1'b1;
      end
      tail_d[push_lvl] = push_id;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q     <= StIdle;
      it_q     <= '0;
      head_q   <= '{default: '0};
      tail_q   <= '{default: '0};
      ne_q     <= '0;
      bcnt_q   <= '0;
      qleft_q  <= '0;
      fresh_q  <= '0;
      bl_q     <= '0;
      res_q    <= '0;
      ov_q     <= '0;
      ovalid_q <= 1'b0;
    end else begin
      if (st_q == StIdle && in_if.valid) it_q <= in_if.data;
      st_q     <= st_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      ne_q     <= ne_d;
      bcnt_q   <= bcnt_d;
      qleft_q  <= qleft_d;
      fresh_q  <= fresh_d;
      bl_q     <= bl_d;
      res_q    <= res_d;
      ov_q     <= ov_d;
      ovalid_q <= ovalid_d;
    end
  end
endmodule
